[sv/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Register indexes, reset values, the configuration bundle and result word.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int WIN_BITS      = 16;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_WINDOW     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS_WINDOW   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS_REPEAT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEEP_ENABLE         = 3'd4;

  // Reset values of the windows (ms)
  localparam logic [WIN_BITS-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [WIN_BITS-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [WIN_BITS-1:0] DOUBLE_CLICK_RESET = 16'd300;

  // Configuration bundle handed to the core
  typedef struct packed {
    logic [WIN_BITS-1:0] debounce_window;
    logic [WIN_BITS-1:0] long_press_window;
    logic [WIN_BITS-1:0] double_click_window;
    logic                long_press_repeat;
    logic                beep_enable;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic click;
    logic double_click;
    logic long_press;
    logic beep_request;
  } result_t;

endpackage

[sv/bcc_core.sv]
// ----------------------------------------------------------------------------
// bcc_core: click classification state and next-state logic
// Holds the debounce, press and click timestamps; computes one result word
// from the registered poll and commits the state update when fire is high.
// ----------------------------------------------------------------------------
module bcc_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  bcc_pkg::cfg_t        cfg,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  output bcc_pkg::result_t     res
);

  localparam logic [TIME_BITS-1:0] TIME_NONE = '0;

  logic                 stable_level_r, stable_level_nxt;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] last_click_time_r, last_click_time_nxt;

  logic [TIME_BITS-1:0] deb_win, lng_win, dbl_win;
  logic [TIME_BITS-1:0] since_press, since_click, since_change;

  assign deb_win = TIME_BITS'(cfg.debounce_window);
  assign lng_win = TIME_BITS'(cfg.long_press_window);
  assign dbl_win = TIME_BITS'(cfg.double_click_window);

  // Elapsed times wrap modulo 2^TIME_BITS
  assign since_press  = now - press_time_r;
  assign since_click  = now - last_click_time_r;
  assign since_change = now - change_time_r;

  // Long press, click expiry, then debounce confirmation
  always_comb begin
    stable_level_nxt    = stable_level_r;
    change_time_nxt     = change_time_r;
    press_time_nxt      = press_time_r;
    last_click_time_nxt = last_click_time_r;
    res                 = '0;

    if (press_time_r != TIME_NONE && since_press > lng_win) begin
      res.long_press = 1'b1;
      press_time_nxt = cfg.long_press_repeat ? now : TIME_NONE;
    end

    if (last_click_time_r != TIME_NONE && since_click > dbl_win) begin
      last_click_time_nxt = TIME_NONE;
    end

    if (change_time_r != TIME_NONE && since_change > deb_win) begin
      if (level == stable_level_r) begin
        if (!level) begin
          press_time_nxt = now;
        end else if (press_time_nxt != TIME_NONE) begin
          res.click = 1'b1;
          // expiry above cleared the stamp when since_click > window
          if (last_click_time_nxt != TIME_NONE && since_click < dbl_win) begin
            res.double_click    = 1'b1;
            last_click_time_nxt = TIME_NONE;
          end else begin
            last_click_time_nxt = now;
          end
          press_time_nxt = TIME_NONE;
        end
      end
      stable_level_nxt = level;
      change_time_nxt  = TIME_NONE;
    end else if (level != stable_level_r && change_time_r == TIME_NONE) begin
      stable_level_nxt = level;
      change_time_nxt  = now;
    end

    res.beep_request = res.click & cfg.beep_enable;
  end

  // State commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r    <= 1'b0;
      change_time_r     <= '0;
      press_time_r      <= '0;
      last_click_time_r <= '0;
    end else if (fire) begin
      stable_level_r    <= stable_level_nxt;
      change_time_r     <= change_time_nxt;
      press_time_r      <= press_time_nxt;
      last_click_time_r <= last_click_time_nxt;
    end
  end

endmodule

[sv/button_click_classifier_top.sv]
// ----------------------------------------------------------------------------
// button_click_classifier_top: debounced click / double click / long press
// Polls an active-low button with a millisecond stamp and returns one
// classification word per poll.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  button_level, now_ms
//   out_     output     out_valid/out_stall click, double_click, long_press,
//                                          beep_request
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low. A taken poll is
// held in the input register, then passes through the single-pass classifier
// into the result register, which drives out_valid.
// Synchronous active-low reset clears the timestamps, stable level, valids and
// restores the register defaults.
// out_stall holds the result register; in_stall rises only when both the
// input register and result register are full and the output is stalled.
// ----------------------------------------------------------------------------
module button_click_classifier_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // poll words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_button_level,
  input  logic [31:0]                      in_now_ms,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_click,
  output logic                             out_double_click,
  output logic                             out_long_press,
  output logic                             out_beep_request,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [bcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  bcc_pkg::cfg_t cfg_r;

  logic                 s1_valid_r;
  logic                 s1_level_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 out_valid_r;
  bcc_pkg::result_t     out_word_r;
  bcc_pkg::result_t     core_res;
  logic                 advance;
  logic                 in_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_window     <= bcc_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_window   <= bcc_pkg::LONG_PRESS_RESET;
      cfg_r.double_click_window <= bcc_pkg::DOUBLE_CLICK_RESET;
      cfg_r.long_press_repeat   <= 1'b0;
      cfg_r.beep_enable         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::REG_DEBOUNCE_WINDOW:     cfg_r.debounce_window     <= cfg_data;
        bcc_pkg::REG_LONG_PRESS_WINDOW:   cfg_r.long_press_window   <= cfg_data;
        bcc_pkg::REG_DOUBLE_CLICK_WINDOW: cfg_r.double_click_window <= cfg_data;
        bcc_pkg::REG_LONG_PRESS_REPEAT:   cfg_r.long_press_repeat   <= cfg_data[0];
        bcc_pkg::REG_BEEP_ENABLE:         cfg_r.beep_enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_button_level;
      s1_now_r   <= TIME_BITS'(in_now_ms);
    end
  end

  bcc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .cfg   (cfg_r),
    .level (s1_level_r),
    .now   (s1_now_r),
    .res   (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_click        = out_word_r.click;
  assign out_double_click = out_word_r.double_click;
  assign out_long_press   = out_word_r.long_press;
  assign out_beep_request = out_word_r.beep_request;

  // Checks
  a_dbl_needs_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_double_click |-> out_click)
    else $error("double click without click");

  a_beep_follows_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beep_request == (out_click && cfg_r.beep_enable)))
    else $error("beep request does not match click and enable");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word did not reach the result register");

endmodule

[bench/button_click_classifier_top_tb.sv]
// ----------------------------------------------------------------------------
// button_click_classifier_top_tb: self-checking bench for the click classifier
// Drives button polls with millisecond stamps: directed press/release cases,
// then bouncy press sessions and noise under many window settings. A local
// model predicts one word per poll and each result word is checked in order.
// ----------------------------------------------------------------------------
module button_click_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake
  localparam int GAP_MAX     = 11;
  localparam int HOLD_LONG   = 200;   // long receiver hold-off

  // DUT signals
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_button_level = 1'b1;
  logic [31:0]                       in_now_ms = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_click;
  logic                              out_double_click;
  logic                              out_long_press;
  logic                              out_beep_request;
  logic                              cfg_we = 1'b0;
  logic [bcc_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [bcc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // Local copy of the classifier state and windows
  logic                         cand_level;
  logic [31:0]                  change_t;
  logic [31:0]                  press_t;
  logic [31:0]                  click_t;
  logic [bcc_pkg::WIN_BITS-1:0] w_debounce;
  logic [bcc_pkg::WIN_BITS-1:0] w_long;
  logic [bcc_pkg::WIN_BITS-1:0] w_double;
  logic                         rep_mode;
  logic                         beep_on;

  // Words predicted and not yet seen on the output
  bcc_pkg::result_t predicted_events[$];

  // Bench control and tallies
  logic [31:0] cur_ts;
  bit          sender_eager = 1'b0;
  bit          receiver_eager = 1'b0;
  int          hold_off_cycles = 0;
  int          mismatch_count = 0;
  int          polls_sent = 0;
  int          settings_count = 0;
  int          clicks_seen = 0;
  int          doubles_seen = 0;
  int          longs_seen = 0;
  int          beeps_seen = 0;

  button_click_classifier_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_level  (in_button_level),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_click        (out_click),
    .out_double_click (out_double_click),
    .out_long_press   (out_long_press),
    .out_beep_request (out_beep_request),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One poll through the classifier: long press, click expiry, debounce
  function automatic bcc_pkg::result_t classify_poll(input logic lvl,
                                                     input logic [31:0] ts);
    bcc_pkg::result_t r;
    logic [31:0]      held;
    logic [31:0]      since_click;
    logic [31:0]      pending;
    r = '0;
    held = ts - press_t;
    if (press_t != 0 && held > {16'd0, w_long}) begin
      r.long_press = 1'b1;
      press_t = rep_mode ? ts : 32'd0;
    end
    since_click = ts - click_t;
    if (click_t != 0 && since_click > {16'd0, w_double}) click_t = '0;
    pending = ts - change_t;
    if (change_t != 0 && pending > {16'd0, w_debounce}) begin
      // timed-out change: confirm only if the level held
      if (lvl == cand_level) begin
        if (lvl == 1'b0) begin
          press_t = ts;
        end else if (press_t != 0) begin
          r.click = 1'b1;
          if (click_t != 0 && since_click < {16'd0, w_double}) begin
            r.double_click = 1'b1;
            click_t = '0;
          end else begin
            click_t = ts;
          end
          press_t = '0;
        end
      end
      cand_level = lvl;
      change_t = '0;
    end else if (lvl != cand_level && change_t == 0) begin
      cand_level = lvl;
      change_t = ts;
    end
    r.beep_request = r.click & beep_on;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] error: %s", $realtime, msg);
  endtask

  // Offer one poll word after a random gap and wait for it to be taken
  task automatic send_poll(input logic lvl, input logic [31:0] ts);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= lvl;
    in_now_ms       <= ts;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted_events.push_back(classify_poll(lvl, ts));
    polls_sent++;
  endtask

  // Stop offering and wait until every predicted word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bcc_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bcc_pkg::REG_DEBOUNCE_WINDOW:     w_debounce = val;
      bcc_pkg::REG_LONG_PRESS_WINDOW:   w_long = val;
      bcc_pkg::REG_DOUBLE_CLICK_WINDOW: w_double = val;
      bcc_pkg::REG_LONG_PRESS_REPEAT:   rep_mode = val[0];
      bcc_pkg::REG_BEEP_ENABLE:         beep_on = val[0];
      default: ;
    endcase
  endtask

  // Write all five registers while idle; flag registers get junk upper bits
  task automatic program_windows(input logic [15:0] db, input logic [15:0] lp,
                                 input logic [15:0] dc, input logic rep,
                                 input logic beep);
    logic [15:0] rep_word;
    logic [15:0] beep_word;
    rep_word     = 16'($urandom());
    rep_word[0]  = rep;
    beep_word    = 16'($urandom());
    beep_word[0] = beep;
    drain_results();
    write_reg(bcc_pkg::REG_DEBOUNCE_WINDOW, db);
    write_reg(bcc_pkg::REG_LONG_PRESS_WINDOW, lp);
    write_reg(bcc_pkg::REG_DOUBLE_CLICK_WINDOW, dc);
    write_reg(bcc_pkg::REG_LONG_PRESS_REPEAT, rep_word);
    write_reg(bcc_pkg::REG_BEEP_ENABLE, beep_word);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [15:0] pick_window();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 120));
  endfunction

  // Typical poll spacing, scaled to the widest window in use
  function automatic int poll_step();
    int widest;
    widest = int'(w_debounce);
    if (int'(w_long) > widest) widest = int'(w_long);
    if (int'(w_double) > widest) widest = int'(w_double);
    return $urandom_range(1, 1 + widest / 4);
  endfunction

  task automatic poll_after(input logic lvl, input int delta);
    cur_ts = cur_ts + delta;
    send_poll(lvl, cur_ts);
  endtask

  // Bouncy press, hold, bouncy release, rest
  task automatic button_session();
    int hold_polls;
    int rest_polls;
    hold_polls = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 3 : 14);
    rest_polls = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 2 : 8);
    repeat ($urandom_range(0, 4))
      poll_after(1'($urandom_range(0, 1)), $urandom_range(0, w_debounce));
    repeat (hold_polls) poll_after(1'b0, poll_step());
    repeat ($urandom_range(0, 4))
      poll_after(1'($urandom_range(0, 1)), $urandom_range(0, w_debounce));
    repeat (rest_polls) poll_after(1'b1, poll_step());
  endtask

  // Malformed traffic: zero stamps, wild jumps, wrap, random levels
  task automatic noise_polls();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: cur_ts = '0;
        1: cur_ts = $urandom();
        2: cur_ts = cur_ts + $urandom_range(0, 64);
        default: cur_ts = 32'hFFFF_FFFF - $urandom_range(0, 200);
      endcase
      send_poll(1'($urandom_range(0, 1)), cur_ts);
    end
  endtask

  task automatic run_phase(input int n_items);
    int stop_at;
    stop_at = polls_sent + n_items;
    while (polls_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) button_session();
      else noise_polls();
    end
  endtask

  // Reset windows: release without press, press, single long press
  task automatic test_reset_defaults();
    send_poll(1'b1, 32'd100);
    send_poll(1'b1, 32'd200);
    send_poll(1'b0, 32'd300);
    send_poll(1'b0, 32'd351);
    send_poll(1'b0, 32'd400);
    send_poll(1'b0, 32'd1400);
    send_poll(1'b0, 32'd2500);
    send_poll(1'b1, 32'd2600);
    send_poll(1'b1, 32'd2700);
  endtask

  // Repeat long press, click with beep, double click, level flip, zero stamp
  task automatic test_click_sequences();
    program_windows(bcc_pkg::DEBOUNCE_RESET, bcc_pkg::LONG_PRESS_RESET,
                    bcc_pkg::DOUBLE_CLICK_RESET, 1'b1, 1'b1);
    send_poll(1'b0, 32'd3000);
    send_poll(1'b0, 32'd3060);
    send_poll(1'b0, 32'd4100);
    send_poll(1'b0, 32'd5200);
    send_poll(1'b1, 32'd5300);
    send_poll(1'b1, 32'd5360);
    send_poll(1'b0, 32'd5400);
    send_poll(1'b0, 32'd5460);
    send_poll(1'b1, 32'd5500);
    send_poll(1'b1, 32'd5560);
    send_poll(1'b0, 32'd5600);
    send_poll(1'b1, 32'd5700);
    send_poll(1'b0, 32'hFFFF_FF00);
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd0);
    send_poll(1'b1, 32'hFFFF_FFFF);
  endtask

  // Sessions across extreme and random window settings
  task automatic test_window_sweep();
    logic [15:0] db;
    logic [15:0] lp;
    logic [15:0] dc;
    for (int ph = 0; ph < 10; ph++) begin
      db = pick_window();
      lp = pick_window();
      dc = pick_window();
      case (ph)
        0: program_windows(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        1: program_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        default: program_windows(db, lp, dc, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
      endcase
      sender_eager   = ($urandom_range(0, 3) == 0);
      receiver_eager = ($urandom_range(0, 3) == 0);
      cur_ts = $urandom();
      run_phase(140);
    end
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
  endtask

  // Receiver holds off while the sender keeps pushing: input must stall
  task automatic test_output_backpressure();
    program_windows(16'd8, 16'd60, 16'd40, 1'b1, 1'b1);
    sender_eager    = 1'b1;
    hold_off_cycles = HOLD_LONG;
    run_phase(60);
    sender_eager = 1'b0;
  endtask

  // Sender pauses with the pipe empty, then resumes
  task automatic test_input_pause();
    run_phase(30);
    drain_results();
    run_phase(30);
  endtask

  // Result monitor: random stall per word, compare against oldest prediction
  initial begin : result_monitor
    int               n;
    bcc_pkg::result_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = receiver_eager ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      clicks_seen  += (out_click === 1'b1);
      doubles_seen += (out_double_click === 1'b1);
      longs_seen   += (out_long_press === 1'b1);
      beeps_seen   += (out_beep_request === 1'b1);
      if (predicted_events.size() == 0) begin
        report_mismatch("result word with nothing predicted");
      end else begin
        want = predicted_events.pop_front();
        if (out_click !== want.click)
          report_mismatch($sformatf("click %b, want %b", out_click, want.click));
        if (out_double_click !== want.double_click)
          report_mismatch($sformatf("double_click %b, want %b",
                                    out_double_click, want.double_click));
        if (out_long_press !== want.long_press)
          report_mismatch($sformatf("long_press %b, want %b",
                                    out_long_press, want.long_press));
        if (out_beep_request !== want.beep_request)
          report_mismatch($sformatf("beep_request %b, want %b",
                                    out_beep_request, want.beep_request));
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence
  initial begin
    cand_level = 1'b0;
    change_t   = '0;
    press_t    = '0;
    click_t    = '0;
    w_debounce = bcc_pkg::DEBOUNCE_RESET;
    w_long     = bcc_pkg::LONG_PRESS_RESET;
    w_double   = bcc_pkg::DOUBLE_CLICK_RESET;
    rep_mode   = 1'b0;
    beep_on    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_click_sequences();
    test_window_sweep();
    test_output_backpressure();
    test_input_pause();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d polls under %0d window settings, incl. long output hold and input pause",
             polls_sent, settings_count);
    $display("Observed %0d clicks, %0d double clicks, %0d long presses, %0d beeps",
             clicks_seen, doubles_seen, longs_seen, beeps_seen);
    if (mismatch_count == 0 && predicted_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
